// ----- hw/rtl/gtac_pkg.sv -----
// Shared types and constants for the 2x4 binary64 tile accumulator.
package gtac_pkg;

  localparam int unsigned LANES = 8;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_ACC  = 1'b1;

  localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;

  typedef struct packed {
    logic        command;
    logic [2:0]  slot;
    logic [63:0] load_value;
    logic [63:0] a_row_zero;
    logic [63:0] a_row_one;
    logic [63:0] b_col_zero;
    logic [63:0] b_col_one;
    logic [63:0] b_col_two;
    logic [63:0] b_col_three;
    logic        last_step;
  } gtac_in_t;

  typedef struct packed {
    logic [63:0] sum_r0_c0;
    logic [63:0] sum_r0_c1;
    logic [63:0] sum_r0_c2;
    logic [63:0] sum_r0_c3;
    logic [63:0] sum_r1_c0;
    logic [63:0] sum_r1_c1;
    logic [63:0] sum_r1_c2;
    logic [63:0] sum_r1_c3;
  } gtac_out_t;

  typedef struct packed {
    logic start;
    logic load;
  } lane_ctrl_t;

  typedef struct packed {
    logic busy;
  } lane_stat_t;

endpackage

// ----- hw/rtl/gemm_tile_2x4_accumulate_core.sv -----
// Top level: input word buffer, eight accumulator lanes and the tile output register.
// A load word writes the accumulator that its slot selects. An accumulate word runs in all
// eight lanes at once, each doing a binary64 multiply (four 27x27 partial products, one per
// cycle), normalize, round, align-and-add, normalize and round; a product of subnormal inputs
// takes longer in the lane's normalizing shifter. The next word is taken into the input
// buffer while the lanes work, and a finished tile waits in the output register without
// holding up the lanes, but no new word is dispatched while a finished tile waits for that
// register to free. The tile is emitted once all lanes have finished the step that carried
// last_step and the output register is free or being read out.
module gemm_tile_2x4_accumulate_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gtac_pkg::gtac_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gtac_pkg::gtac_out_t out_data
);
  import gtac_pkg::*;

  gtac_in_t    buf_r;
  logic        buf_v_r;
  logic        pend_r;
  gtac_out_t   out_r;
  logic        out_v_r;

  lane_ctrl_t  ctrl   [LANES];
  lane_stat_t  stat   [LANES];
  logic [63:0] acc    [LANES];
  logic [LANES-1:0] busy_vec;

  logic all_idle;
  logic go;
  logic capture;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      busy_vec[i] = stat[i].busy;
    end
  end

  assign all_idle = (busy_vec == '0);
  assign go       = buf_v_r && all_idle && !pend_r;
  assign capture  = pend_r && all_idle && (!out_v_r || out_ready);
  assign in_ready = !buf_v_r;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [63:0] a_sel;
    logic [63:0] b_sel;
    always_comb begin
      a_sel = (g / 4 == 0) ? buf_r.a_row_zero : buf_r.a_row_one;
      case (g % 4)
        0:       b_sel = buf_r.b_col_zero;
        1:       b_sel = buf_r.b_col_one;
        2:       b_sel = buf_r.b_col_two;
        default: b_sel = buf_r.b_col_three;
      endcase
      ctrl[g].start = go && (buf_r.command == CMD_ACC);
      ctrl[g].load  = go && (buf_r.command == CMD_LOAD) && (buf_r.slot == 3'(g));
    end
    gtac_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl[g]),
      .a_in     (a_sel),
      .b_in     (b_sel),
      .load_val (buf_r.load_value),
      .stat     (stat[g]),
      .acc      (acc[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_v_r <= 1'b0;
      pend_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        buf_v_r <= 1'b1;
      end else if (go) begin
        buf_v_r <= 1'b0;
      end
      if (go && (buf_r.command == CMD_ACC) && buf_r.last_step) begin
        pend_r <= 1'b1;
      end else if (capture) begin
        pend_r <= 1'b0;
      end
      if (capture) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_r <= in_data;
    end
    if (capture) begin
      out_r.sum_r0_c0 <= acc[0];
      out_r.sum_r0_c1 <= acc[1];
      out_r.sum_r0_c2 <= acc[2];
      out_r.sum_r0_c3 <= acc[3];
      out_r.sum_r1_c0 <= acc[4];
      out_r.sum_r1_c1 <= acc[5];
      out_r.sum_r1_c2 <= acc[6];
      out_r.sum_r1_c3 <= acc[7];
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_step_starts_all: assert property (@(posedge clk) disable iff (!rst_n)
    (go && (buf_r.command == CMD_ACC)) |=> ($countones(busy_vec) == LANES))
    else $error("accumulate step did not start every lane");

  a_emit_from_pending: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(pend_r))
    else $error("tile emitted without a finished last step");

  a_pending_held: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !all_idle) |=> pend_r)
    else $error("pending tile dropped while lanes still busy");

endmodule

// ----- hw/rtl/gtac_lane.sv -----
// One accumulator lane: multi-cycle binary64 multiply then add into its own sum.
module gtac_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  gtac_pkg::lane_ctrl_t ctrl,
  input  logic [63:0]         a_in,
  input  logic [63:0]         b_in,
  input  logic [63:0]         load_val,
  output gtac_pkg::lane_stat_t stat,
  output logic [63:0]         acc
);
  import gtac_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_NORM = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;

  function automatic logic f_nan(input logic [63:0] x);
    return (&x[62:52]) && (|x[51:0]);
  endfunction

  function automatic logic f_inf(input logic [63:0] x);
    return (&x[62:52]) && !(|x[51:0]);
  endfunction

  function automatic logic f_zero(input logic [63:0] x);
    return !(|x[62:0]);
  endfunction

  function automatic logic [52:0] f_mant(input logic [63:0] x);
    return {|x[62:52], x[51:0]};
  endfunction

  function automatic logic [10:0] f_exp(input logic [63:0] x);
    return (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
  endfunction

  // m has its leading one at bit 63, e is the biased exponent of that bit
  function automatic logic [63:0] round_pack(input logic s, input logic signed [12:0] e,
                                             input logic [63:0] m);
    logic [6:0]        sh;
    logic [63:0]       ms;
    logic              lost;
    logic              inc;
    logic [10:0]       ef;
    logic [62:0]       mag;
    logic signed [13:0] neg;
    if (e >= 13'sd2047) begin
      return {s, 11'h7FF, 52'd0};
    end
    if (e < 13'sd1) begin
      neg = 14'sd1 - 14'(e);
      sh  = (neg > 14'sd64) ? 7'd64 : neg[6:0];
      ef  = 11'd0;
    end else begin
      neg = 14'sd0;
      sh  = 7'd0;
      ef  = e[10:0];
    end
    ms   = m >> sh;
    lost = |(m & ~({64{1'b1}} << sh));
    inc  = ms[10] & ((|ms[9:0]) | lost | ms[11] | neg[13]);
    // carry out of the fraction walks into the exponent, up to infinity
    mag  = {ef, ms[62:11]} + {62'd0, inc};
    return {s, mag};
  endfunction

  logic [2:0]         st_r, st_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               add_ph_r, add_ph_nxt;
  logic [63:0]        a_r, a_nxt, b_r, b_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic [63:0]        pb_r, pb_nxt;
  logic [105:0]       w_r, w_nxt;
  logic signed [12:0] e_r, e_nxt;
  logic               s_r, s_nxt;

  logic [52:0]  ma, mb;
  logic [26:0]  px, py;
  logic [53:0]  pp;
  logic [105:0] ppw;
  logic         smul;

  logic [63:0]  ax, ay, big, sml;
  logic [10:0]  ebig, esml, d;
  logic [6:0]   dc;
  logic [65:0]  xw, yw, ys;
  logic [65:0]  rsum;
  logic         ylost;

  always_comb begin
    ma   = f_mant(a_r);
    mb   = f_mant(b_r);
    px   = cnt_r[1] ? {1'b0, ma[52:27]} : ma[26:0];
    py   = cnt_r[0] ? {1'b0, mb[52:27]} : mb[26:0];
    pp   = 54'(px) * 54'(py);
    case (cnt_r)
      2'd0:    ppw = 106'(pp);
      2'd3:    ppw = 106'(pp) << 54;
      default: ppw = 106'(pp) << 27;
    endcase
    smul = a_r[63] ^ b_r[63];

    ax  = acc_r;
    ay  = pb_r;
    big = (ax[62:0] >= ay[62:0]) ? ax : ay;
    sml = (ax[62:0] >= ay[62:0]) ? ay : ax;
    ebig  = f_exp(big);
    esml  = f_exp(sml);
    d     = ebig - esml;
    dc    = (d > 11'd65) ? 7'd66 : d[6:0];
    xw    = {1'b0, f_mant(big), 12'd0};
    yw    = {1'b0, f_mant(sml), 12'd0};
    ylost = |(yw & ~({66{1'b1}} << dc));
    ys    = (yw >> dc) | {65'd0, ylost};
    rsum  = (big[63] ^ sml[63]) ? (xw - ys) : (xw + ys);
  end

  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    add_ph_nxt = add_ph_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    acc_nxt    = acc_r;
    pb_nxt     = pb_r;
    w_nxt      = w_r;
    e_nxt      = e_r;
    s_nxt      = s_r;
    unique case (st_r)
      S_IDLE: begin
        if (ctrl.load) begin
          acc_nxt = load_val;
        end
        if (ctrl.start) begin
          a_nxt   = a_in;
          b_nxt   = b_in;
          cnt_nxt = 2'd0;
          st_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        w_nxt   = ((cnt_r == 2'd0) ? 106'd0 : w_r) + ppw;
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd0) begin
          add_ph_nxt = 1'b0;
          s_nxt      = smul;
          e_nxt      = $signed({2'b00, f_exp(a_r)}) + $signed({2'b00, f_exp(b_r)})
                       - 13'sd1022;
          if (f_nan(a_r) || f_nan(b_r) || (f_inf(a_r) && f_zero(b_r)) ||
              (f_zero(a_r) && f_inf(b_r))) begin
            pb_nxt = CANON_NAN;
            st_nxt = S_ADD;
          end else if (f_inf(a_r) || f_inf(b_r)) begin
            pb_nxt = {smul, 11'h7FF, 52'd0};
            st_nxt = S_ADD;
          end else if (f_zero(a_r) || f_zero(b_r)) begin
            pb_nxt = {smul, 63'd0};
            st_nxt = S_ADD;
          end
        end else if (cnt_r == 2'd3) begin
          st_nxt = S_NORM;
        end
      end
      S_NORM: begin
        // coarse steps first so deep subnormal products finish quickly
        if (w_r[105]) begin
          st_nxt = S_RND;
        end else if (w_r[105:74] == 32'd0) begin
          w_nxt = w_r << 32;
          e_nxt = e_r - 13'sd32;
        end else if (w_r[105:98] == 8'd0) begin
          w_nxt = w_r << 8;
          e_nxt = e_r - 13'sd8;
        end else begin
          w_nxt = w_r << 1;
          e_nxt = e_r - 13'sd1;
        end
      end
      S_RND: begin
        if (add_ph_r) begin
          acc_nxt = round_pack(s_r, e_r, {w_r[105:43], |w_r[42:0]});
          st_nxt  = S_IDLE;
        end else begin
          pb_nxt = round_pack(s_r, e_r, {w_r[105:43], |w_r[42:0]});
          st_nxt = S_ADD;
        end
      end
      S_ADD: begin
        st_nxt = S_IDLE;
        if (f_nan(ax) || f_nan(ay) || (f_inf(ax) && f_inf(ay) && (ax[63] != ay[63]))) begin
          acc_nxt = CANON_NAN;
        end else if (f_inf(ax)) begin
          acc_nxt = ax;
        end else if (f_inf(ay)) begin
          acc_nxt = ay;
        end else if (f_zero(ax) && f_zero(ay)) begin
          acc_nxt = {ax[63] & ay[63], 63'd0};
        end else if (f_zero(ax)) begin
          acc_nxt = ay;
        end else if (f_zero(ay)) begin
          acc_nxt = ax;
        end else if (rsum == 66'd0) begin
          acc_nxt = 64'd0;
        end else begin
          w_nxt      = {rsum, 40'd0};
          e_nxt      = $signed({2'b00, ebig}) + 13'sd1;
          s_nxt      = big[63];
          add_ph_nxt = 1'b1;
          st_nxt     = S_NORM;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      cnt_r    <= 2'd0;
      add_ph_r <= 1'b0;
      acc_r    <= 64'd0;
    end else begin
      st_r     <= st_nxt;
      cnt_r    <= cnt_nxt;
      add_ph_r <= add_ph_nxt;
      acc_r    <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    pb_r <= pb_nxt;
    w_r  <= w_nxt;
    e_r  <= e_nxt;
    s_r  <= s_nxt;
  end

  assign stat.busy = (st_r != S_IDLE);
  assign acc       = acc_r;

endmodule
